[rtl/core/b32d_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b32d_pkg
// Shared types, constants and character helpers for the base32 stream decoder.
// ----------------------------------------------------------------------------
package b32d_pkg;

  localparam int GROUP_W    = 40;
  localparam int GROUP_SLOTS = 8;
  localparam int SYM_W      = 5;
  localparam int JOB_DEPTH  = 4;
  localparam int JOB_AW     = $clog2(JOB_DEPTH);

  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_TWO     = 8'h32;
  localparam logic [7:0] CHAR_SEVEN   = 8'h37;
  localparam logic [7:0] CHAR_ONE     = 8'h31;
  localparam logic [7:0] CHAR_PAD     = 8'h3d;
  localparam logic [4:0] DIGIT_BASE   = 5'd26;
  localparam logic [4:0] ONE_AS_I     = 5'd8;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_string;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       group_last;
    logic       string_done;
    logic       bad_char;
  } out_beat_t;

  typedef struct packed {
    logic [GROUP_W-1:0] bits;
    logic [2:0]         byte_cnt;
    logic               eos;
    logic               err;
  } job_t;

  typedef struct packed {
    logic       ok;
    logic       pad;
    logic [4:0] val;
  } char_class_t;

  function automatic char_class_t classify_char(input logic [7:0] c);
    logic [7:0]  u;
    char_class_t r;
    u = (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ? c - CASE_OFFSET : c;
    r = '{ok: 1'b1, pad: 1'b0, val: 5'd0};
    if (u >= CHAR_UPPER_A && u <= CHAR_UPPER_Z) begin
      r.val = 5'(u - CHAR_UPPER_A);
    end else if (u >= CHAR_TWO && u <= CHAR_SEVEN) begin
      r.val = 5'(u - CHAR_TWO) + DIGIT_BASE;
    end else if (u == CHAR_PAD) begin
      r.pad = 1'b1;
    end else if (u == CHAR_ONE) begin
      r.val = ONE_AS_I;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [2:0] byte_count(input logic [3:0] idx);
    logic [2:0] n;
    unique case (idx)
      4'd1, 4'd2: n = 3'd1;
      4'd3, 4'd4: n = 3'd2;
      4'd5:       n = 3'd3;
      4'd6, 4'd7: n = 3'd4;
      default:    n = 3'd5;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

[rtl/core/base32_stream_decoder_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// base32_stream_decoder_unit
// Streaming base32 decoder: one character in per beat, decoded bytes out.
// ----------------------------------------------------------------------------
// The decoder accepts one character per clock cycle. Each group of eight
// characters, or the shorter group closed by the end-of-string flag, becomes a
// job in a four-entry queue; the output side then delivers that group's one to
// five bytes at one byte per cycle while the consumer pops. A job enters the
// queue in the same cycle its closing character is accepted, and its first byte
// reaches the output through the queue memory and the back's job register when
// the output side is free. Input is held off only while the queue is full. A
// group never yields more bytes than it has characters, so this happens only
// when the consumer stalls. A string with an invalid character ends with a
// single beat that has bad_char set, and its earlier bytes are to be discarded.
module base32_stream_decoder_unit (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_push,
  output logic                 in_full,
  input  b32d_pkg::in_beat_t   in_beat,
  output logic                 out_empty,
  input  wire                  out_pop,
  output b32d_pkg::out_beat_t  out_beat
);
  import b32d_pkg::*;

  job_t wr_job;
  job_t rd_job;
  logic job_push;
  logic job_pop;
  logic job_full;
  logic job_empty;

  b32d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_beat  (in_beat),
    .job_full (job_full),
    .in_full  (in_full),
    .job_push (job_push),
    .job      (wr_job)
  );

  b32d_job_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (wr_job),
    .pop   (job_pop),
    .full  (job_full),
    .empty (job_empty),
    .rdata (rd_job)
  );

  b32d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job       (rd_job),
    .job_pop   (job_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_beat  (out_beat)
  );

endmodule
`default_nettype wire

[rtl/core/b32d_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b32d_front
// Classifies characters, builds the 40-bit group and queues one job per group.
// ----------------------------------------------------------------------------
module b32d_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_push,
  input  b32d_pkg::in_beat_t  in_beat,
  input  wire                 job_full,
  output logic                in_full,
  output logic                job_push,
  output b32d_pkg::job_t      job
);
  import b32d_pkg::*;

  logic [GROUP_W-1:0] group_r;
  logic [2:0]         count_r;
  logic [2:0]         pad_pos_r;
  logic               err_r;

  char_class_t        cls;
  logic               accept;
  logic               err_nxt;
  logic [2:0]         pad_pos_nxt;
  logic [GROUP_W-1:0] slot_bits;
  logic [GROUP_W-1:0] group_nxt;
  logic               complete;
  logic [2:0]         n_bytes;

  always_comb begin
    cls         = classify_char(in_beat.char_code);
    accept      = in_push && !job_full;
    err_nxt     = err_r || !cls.ok;
    pad_pos_nxt = (cls.pad && pad_pos_r == 3'd0) ? count_r : pad_pos_r;
    slot_bits   = '0;
    for (int s = 0; s < GROUP_SLOTS; s++) begin
      if (count_r == 3'(s)) begin
        slot_bits[GROUP_W-1-SYM_W*s -: SYM_W] = cls.val;
      end
    end
    group_nxt = err_nxt ? group_r : (group_r | slot_bits);
    complete  = (count_r == 3'd7) || in_beat.end_of_string;
    n_bytes   = (count_r == 3'd7) ? byte_count({1'b0, pad_pos_nxt})
                                  : byte_count({1'b0, count_r} + 4'd1);
    job_push  = accept && complete && (!err_nxt || in_beat.end_of_string);
    if (err_nxt) begin
      job = '{bits: '0, byte_cnt: 3'd1, eos: 1'b1, err: 1'b1};
    end else begin
      job = '{bits: group_nxt, byte_cnt: n_bytes, eos: in_beat.end_of_string, err: 1'b0};
    end
  end

  assign in_full = job_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r   <= '0;
      count_r   <= '0;
      pad_pos_r <= '0;
      err_r     <= 1'b0;
    end else if (accept) begin
      if (complete) begin
        group_r   <= '0;
        count_r   <= '0;
        pad_pos_r <= '0;
        err_r     <= in_beat.end_of_string ? 1'b0 : err_nxt;
      end else begin
        group_r   <= group_nxt;
        count_r   <= count_r + 3'd1;
        pad_pos_r <= pad_pos_nxt;
        err_r     <= err_nxt;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/b32d_job_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b32d_job_fifo
// Short queue of group jobs between the front and the back.
// ----------------------------------------------------------------------------
module b32d_job_fifo (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  b32d_pkg::job_t  wdata,
  input  wire             pop,
  output logic            full,
  output logic            empty,
  output b32d_pkg::job_t  rdata
);
  import b32d_pkg::*;

  job_t              mem_r [JOB_DEPTH];
  logic [JOB_AW-1:0] wr_ptr_r;
  logic [JOB_AW-1:0] rd_ptr_r;
  logic [JOB_AW:0]   count_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == (JOB_AW+1)'(JOB_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/b32d_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b32d_back
// Holds one job and hands out its bytes, most significant first, one per beat.
// ----------------------------------------------------------------------------
module b32d_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  job_empty,
  input  b32d_pkg::job_t       job,
  output logic                 job_pop,
  input  wire                  out_pop,
  output logic                 out_empty,
  output b32d_pkg::out_beat_t  out_beat
);
  import b32d_pkg::*;

  job_t       job_r;
  logic       valid_r;
  logic [2:0] idx_r;
  logic       last;
  logic       take;
  logic [7:0] byte_sel;

  always_comb begin
    last = (idx_r + 3'd1 == job_r.byte_cnt);
    take = !valid_r || (out_pop && last);
    case (idx_r)
      3'd0:    byte_sel = job_r.bits[39:32];
      3'd1:    byte_sel = job_r.bits[31:24];
      3'd2:    byte_sel = job_r.bits[23:16];
      3'd3:    byte_sel = job_r.bits[15:8];
      3'd4:    byte_sel = job_r.bits[7:0];
      default: byte_sel = 8'd0;
    endcase
    out_beat = '{data_byte: byte_sel, group_last: last, string_done: last && job_r.eos,
                 bad_char: job_r.err};
  end

  assign job_pop   = take && !job_empty;
  assign out_empty = !valid_r;

  always_ff @(posedge clk) begin
    if (take) begin
      job_r <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (take) begin
      valid_r <= !job_empty;
      idx_r   <= '0;
    end else if (out_pop) begin
      idx_r <= idx_r + 3'd1;
    end
  end

endmodule
`default_nettype wire

[verif/tb_base32_stream_decoder_unit.sv]
// ----------------------------------------------------------------------------
// tb_base32_stream_decoder_unit
// Self-checking bench for the streaming base32 decoder. Strings of characters
// are pushed one beat at a time and every decoded byte beat, including the
// error beat of a string with a bad character, is predicted and compared in
// order. A directed set of strings comes first, then random strings under
// several idle and stall mixes on both sides of the block.
// ----------------------------------------------------------------------------
module tb_base32_stream_decoder_unit;
  import b32d_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 150;

  class b32_byte_scoreboard;
    out_beat_t   expected_bytes[$];
    int          mismatches = 0;
    logic [39:0] group_acc  = '0;
    logic [2:0]  char_cnt   = '0;
    logic [2:0]  pad_pos    = '0;
    logic        err_flag   = 1'b0;
    int          bytes_for_fill [9] = '{5, 1, 1, 2, 2, 3, 4, 4, 5};

    function void clear_group();
      group_acc = '0;
      char_cnt  = '0;
      pad_pos   = '0;
    endfunction

    function void absorb_char(in_beat_t b);
      logic [7:0] c;
      logic [4:0] v;
      logic [2:0] pos;
      logic       full;
      int         n;
      out_beat_t  r;
      c   = b.char_code;
      pos = char_cnt;
      v   = '0;
      if (c >= "a" && c <= "z") c = c - 8'h20;
      if (c >= "A" && c <= "Z") begin
        v = 5'(c - "A");
      end else if (c >= "2" && c <= "7") begin
        v = 5'(c - "2") + 5'd26;
      end else if (c == "=") begin
        if (pad_pos == 3'd0) pad_pos = pos;
      end else if (c == "1") begin
        v = 5'(8'("I") - 8'("A"));
      end else begin
        err_flag = 1'b1;
      end
      if (!err_flag) group_acc = group_acc | (40'(v) << (35 - 5 * pos));
      full = (pos == 3'd7);
      if (!full && !b.end_of_string) begin
        char_cnt = pos + 3'd1;
        return;
      end
      if (err_flag) begin
        clear_group();
        if (b.end_of_string) begin
          err_flag = 1'b0;
          r = '{data_byte: 8'h00, group_last: 1'b1, string_done: 1'b1, bad_char: 1'b1};
          expected_bytes.push_back(r);
        end
        return;
      end
      n = full ? bytes_for_fill[pad_pos] : bytes_for_fill[int'(pos) + 1];
      for (int k = 0; k < n; k++) begin
        r.data_byte   = group_acc[39 - 8 * k -: 8];
        r.group_last  = (k == n - 1);
        r.string_done = (k == n - 1) && b.end_of_string;
        r.bad_char    = 1'b0;
        expected_bytes.push_back(r);
      end
      clear_group();
    endfunction

    function void check_byte(out_beat_t got);
      out_beat_t want;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: byte=%h last=%b done=%b bad=%b",
                   got.data_byte, got.group_last, got.string_done, got.bad_char);
        return;
      end
      want = expected_bytes.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                   want.data_byte, want.group_last, want.string_done, want.bad_char,
                   got.data_byte, got.group_last, got.string_done, got.bad_char);
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_push   = 1'b0;
  in_beat_t  in_beat   = '0;
  logic      out_pop   = 1'b0;
  logic      in_full;
  logic      out_empty;
  out_beat_t out_beat;

  b32_byte_scoreboard sb = new();
  int gap_pct     = 0;
  int stall_pct   = 0;
  int items_sent  = 0;
  int cycle_count = 0;

  base32_stream_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_beat   (in_beat),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_beat  (out_beat)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) sb.check_byte(out_beat);
    out_pop <= ($urandom_range(99) >= stall_pct);
  end

  task automatic push_char(input logic [7:0] c, input logic eos);
    while ($urandom_range(99) < gap_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_beat <= '{char_code: c, end_of_string: eos};
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.absorb_char(in_beat);
    items_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] random_symbol();
    case ($urandom_range(7))
      0, 1:    return 8'("A") + 8'($urandom_range(25));
      2:       return 8'("a") + 8'($urandom_range(25));
      3, 4:    return 8'("2") + 8'($urandom_range(5));
      5:       return 8'("1");
      default: return ($urandom_range(1) == 0) ? 8'("=") : 8'("A") + 8'($urandom_range(25));
    endcase
  endfunction

  task automatic push_random_string();
    int         len;
    int         bad_at;
    logic       noise;
    logic [7:0] c;
    len    = ($urandom_range(9) == 0) ? $urandom_range(17, 32) : $urandom_range(1, 16);
    noise  = ($urandom_range(19) == 0);
    bad_at = ($urandom_range(9) == 0) ? $urandom_range(len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      if (noise) begin
        c = 8'($urandom_range(255));
      end else if (i == bad_at) begin
        do c = 8'($urandom_range(255));
        while ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "1" && c <= "7") || c == "=");
      end else begin
        c = random_symbol();
      end
      push_char(c, i == len - 1);
    end
  endtask

  initial begin
    int    phase_gap   [4] = '{0, 49, 0, 9};
    int    phase_stall [4] = '{0, 0, 49, 9};
    string pad_group       = "=7azAZ2Q";
    int    target;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_text("MZXW6Y==");
    for (int i = 0; i < 8; i++) push_char(pad_group[i], 1'b0);
    push_char("1", 1'b1);
    push_char(8'hff, 1'b0);
    push_char("Q", 1'b0);
    push_char(8'h00, 1'b1);
    push_text("z2");
    push_text("=");

    for (int p = 0; p < 4; p++) begin
      gap_pct   = phase_gap[p];
      stall_pct = phase_stall[p];
      target    = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < target) push_random_string();
    end
    in_push <= 1'b0;

    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
